### src/cgr_pkg.sv
// Shared types and constants for the calibration grid rotator.
`default_nettype none

package cgr_pkg;

   localparam int GRID_MAX_DEF    = 32;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int FIELD_W = 32;  // width of a Q16.16 offset on the ports
   localparam int IDX_W   = 5;   // row / col field width
   localparam int SIZE_W  = 6;   // grid_size register width
   localparam int CMP_W   = SIZE_W + 1;  // holds the grid size and GRID_MAX
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // register index, taken from paddr[2]
   localparam logic REG_ROTATION  = 1'b0;
   localparam logic REG_GRID_SIZE = 1'b1;

   typedef enum logic [1:0] {
      ROT_NONE,
      ROT_CCW90,
      ROT_CW90,
      ROT_180
   } rot_mode_type;

   typedef enum logic {
      FUNC_LOAD,
      FUNC_READ
   } func_type;

   typedef struct packed {
      func_type                   func;
      logic [IDX_W-1:0]           row;
      logic [IDX_W-1:0]           col;
      logic signed [FIELD_W-1:0]  dx_in;
      logic signed [FIELD_W-1:0]  dy_in;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0]  dx_out;
      logic signed [FIELD_W-1:0]  dy_out;
      logic                       index_error;
   } rsp_type;

endpackage

`default_nettype wire

### src/cgr_store.sv
// Offset vector memory: one write port, one read port, registered read data.
`default_nettype none

module cgr_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 64
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/calibration_grid_rotator.sv
// Top level of the calibration grid rotator: CSRs, index mapping, sign handling.
`default_nettype none

// The block keeps a GRID_MAX x GRID_MAX grid of (dx, dy) calibration offsets
// in signed Q16.16 and returns them rotated by the configured mounting angle
// (none, +90 ccw, -90, 180). A load word with func = load stores dx_in/dy_in,
// saturated to VALUE_WIDTH bits, at (row, col) and returns nothing. A word
// with func = read returns the vector that lands at (row, col) after rotation,
// with components swapped and negated as the angle demands; negating the most
// negative value gives the most positive. Any word whose row or col is not
// below grid_size (capped at GRID_MAX) returns one word with index_error set
// and zero offsets, and an out-of-range load writes nothing.
// Throughput is one word per clock while the result channel does not stall.
// The storage memory's registered read port captures the entry at the
// request's accept edge, and the output register loads it from the read
// stage once the result channel is free. A load lands in the memory at its
// accept edge, so a read accepted in the next cycle already sees it. Result
// stalls back up through the single read stage into req_ready. The grid
// contents are undefined after reset until written; there is no clear pass.
// CSRs: 0x0 rotation_mode[1:0], 0x4 grid_size[5:0]; write only while idle.

module calibration_grid_rotator
   import cgr_pkg::*;
#(
   parameter int GRID_MAX    = GRID_MAX_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   // register port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready
);

   localparam int VW    = VALUE_WIDTH;
   localparam int IW    = $clog2(GRID_MAX);
   localparam int DEPTH = GRID_MAX * GRID_MAX;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = 2 * VW;

   localparam logic signed [VW-1:0]    VMAX  = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0]    VMIN  = {1'b1, {(VW-1){1'b0}}};
   localparam logic        [CMP_W-1:0] GMAX  = CMP_W'(GRID_MAX);
   localparam logic        [AW-1:0]    GSTEP = AW'(GRID_MAX);

   // ---------------------------------------------------------------- CSRs
   rot_mode_type      rotation_mode_ff, rotation_mode_in;
   logic [SIZE_W-1:0] grid_size_ff, grid_size_in;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      rotation_mode_in = rotation_mode_ff;
      grid_size_in     = grid_size_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            REG_ROTATION:  rotation_mode_in = rot_mode_type'(pwdata[1:0]);
            REG_GRID_SIZE: grid_size_in     = pwdata[SIZE_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_ROTATION:  prdata = CSR_DW'(rotation_mode_ff);
         REG_GRID_SIZE: prdata = CSR_DW'(grid_size_ff);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_mode_ff <= ROT_NONE;
         grid_size_ff     <= SIZE_W'(32);
      end else begin
         rotation_mode_ff <= rotation_mode_in;
         grid_size_ff     <= grid_size_in;
      end
   end

   // ------------------------------------------------- request decode
   logic [CMP_W-1:0] size_ext, n_c, m_c, row_c, col_c, sr_c, sc_c;
   logic             in_range, is_load, accept;
   rot_mode_type     addr_mode;
   logic [AW-1:0]    addr_c;

   assign size_ext = CMP_W'(grid_size_ff);
   assign n_c      = (size_ext > GMAX) ? GMAX : size_ext;  // size caps at GRID_MAX
   assign m_c      = n_c - CMP_W'(1);
   assign row_c    = CMP_W'(req_data.row);
   assign col_c    = CMP_W'(req_data.col);
   assign in_range = (row_c < n_c) && (col_c < n_c);
   assign is_load  = (req_data.func == FUNC_LOAD);
   assign accept   = req_valid & req_ready;

   // loads address the grid unrotated
   assign addr_mode = is_load ? ROT_NONE : rotation_mode_ff;

   always_comb begin
      case (addr_mode)
         ROT_CCW90: begin sr_c = col_c;        sc_c = m_c - row_c; end
         ROT_CW90:  begin sr_c = m_c - col_c;  sc_c = row_c;       end
         ROT_180:   begin sr_c = m_c - row_c;  sc_c = m_c - col_c; end
         default:   begin sr_c = row_c;        sc_c = col_c;       end
      endcase
   end

   // source row/col are below GRID_MAX whenever the word is in range
   assign addr_c = AW'(sr_c[IW-1:0]) * GSTEP + AW'(sc_c[IW-1:0]);

   // saturate port values to VALUE_WIDTH
   logic signed [VW-1:0] dx_trunc, dy_trunc, dx_sat, dy_sat;

   assign dx_trunc = req_data.dx_in[VW-1:0];
   assign dy_trunc = req_data.dy_in[VW-1:0];
   assign dx_sat   = (FIELD_W'(dx_trunc) == req_data.dx_in) ? dx_trunc :
                     (req_data.dx_in[FIELD_W-1] ? VMIN : VMAX);
   assign dy_sat   = (FIELD_W'(dy_trunc) == req_data.dy_in) ? dy_trunc :
                     (req_data.dy_in[FIELD_W-1] ? VMIN : VMAX);

   // ------------------------------------------------------- storage
   logic          wr_en, rd_en;
   logic [DW-1:0] rd_data;

   assign wr_en = accept & is_load & in_range;
   assign rd_en = accept & ~is_load & in_range;

   cgr_store #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (DW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_c),
      .wr_data ({dy_sat, dx_sat}),
      .rd_en   (rd_en),
      .rd_addr (addr_c),
      .rd_data (rd_data)
   );

   // --------------------------------------------- read stage (s1)
   // s1 tracks the word whose memory read is in flight, or an error word.
   logic         s1_valid_ff, s1_valid_in;
   logic         s1_err_ff, s1_err_in;
   rot_mode_type s1_mode_ff, s1_mode_in;
   logic         out_free;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = ~s1_valid_ff | out_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_err_in   = s1_err_ff;
      s1_mode_in  = s1_mode_ff;
      if (req_ready) begin
         // an in-range load is the only word that gives no result
         s1_valid_in = accept & ~(is_load & in_range);
         s1_err_in   = ~in_range;
         s1_mode_in  = rotation_mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_err_ff  <= s1_err_in;
      s1_mode_ff <= s1_mode_in;
   end

   // ------------------------------------------- rotate components
   logic signed [VW-1:0] src_dx, src_dy, neg_dx, neg_dy, rot_dx, rot_dy;

   assign src_dx = rd_data[VW-1:0];
   assign src_dy = rd_data[DW-1:VW];
   assign neg_dx = (src_dx == VMIN) ? VMAX : -src_dx;
   assign neg_dy = (src_dy == VMIN) ? VMAX : -src_dy;

   always_comb begin
      case (s1_mode_ff)
         ROT_CCW90: begin rot_dx = src_dy; rot_dy = neg_dx; end
         ROT_CW90:  begin rot_dx = neg_dy; rot_dy = src_dx; end
         ROT_180:   begin rot_dx = neg_dx; rot_dy = neg_dy; end
         default:   begin rot_dx = src_dx; rot_dy = src_dy; end
      endcase
   end

   // ------------------------------------------------ output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_err_ff) begin
            rsp_data_in.dx_out      = '0;
            rsp_data_in.dy_out      = '0;
            rsp_data_in.index_error = 1'b1;
         end else begin
            rsp_data_in.dx_out      = FIELD_W'(rot_dx);
            rsp_data_in.dy_out      = FIELD_W'(rot_dy);
            rsp_data_in.index_error = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
